>>> src/second_chance_page_replacement_defines.svh
// assertion macros for the second chance page replacement checker
// no dependencies; expects clock and reset in the including scope
`ifndef SECOND_CHANCE_PAGE_REPLACEMENT_DEFINES_SVH
`define SECOND_CHANCE_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define SCPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/scpr_pkg.sv
// shared types for the second chance page replacement block
// no dependencies
package scpr_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SWEEP,
      ST_EVICT
   } scpr_state_type;

   localparam int CfgBits   = 5;
   localparam int PortPage  = 8;
   localparam int PortIndex = 4;
   localparam int CountBits = 16;

endpackage

>>> src/scpr_ram.sv
// generic single write port ram with registered read
// no dependencies
module scpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/second_chance_page_replacement.sv
// second chance page replacement: frame table, sequencer and result register
// depends on scpr_pkg and scpr_ram
//
// usage
//   request: drive req_page_number and raise start while busy is low; the
//   reference is taken at that clock edge and busy stays high until done.
//   result: rsp_valid pulses for one cycle with fault, frame index, evicted
//   page and the saturating fault total; the receiver cannot stall it.
//   csr: csr_frame_count is written on a csr_valid and csr_ready transfer,
//   only while busy is low; values are clamped to 1..MAX_FRAMES.
// operation (n = frames in use)
//   the page table ram is scanned one frame per cycle for a hit; its read is
//   registered, each read frame is compared with the page, and a hit sets the
//   registered rsp_valid. a miss scans all n frames, then the hand walks one
//   frame per cycle over at most n+1 frames, clearing set reference bits; a
//   victim's page is read out before eviction, an empty frame is just filled.
//   the next request can be taken in the cycle rsp_valid is high.
// reset
//   synchronous; clears valid and reference bits, hand, fault count, sets
//   the frame count to 4. page contents are not cleared.
module second_chance_page_replacement #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [scpr_pkg::PortPage-1:0]  req_page_number,
   output logic                           rsp_valid,
   output logic                           rsp_fault,
   output logic [scpr_pkg::PortIndex-1:0] rsp_frame_index,
   output logic                           rsp_evicted_valid,
   output logic [scpr_pkg::PortPage-1:0]  rsp_evicted_page,
   output logic [scpr_pkg::CountBits-1:0] rsp_fault_total,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [scpr_pkg::CfgBits-1:0]   csr_frame_count
);

   localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NW = $clog2(MAX_FRAMES + 1);
   localparam int SW = (PAGE_BITS < scpr_pkg::PortPage) ? PAGE_BITS : scpr_pkg::PortPage;

   scpr_pkg::scpr_state_type state_ff, state_in;

   logic [scpr_pkg::CfgBits-1:0]   frame_count_ff, frame_count_in;
   logic [MAX_FRAMES-1:0]          valid_ff, valid_in;
   logic [MAX_FRAMES-1:0]          ref_ff, ref_in;
   logic [IW-1:0]                  hand_ff, hand_in;
   logic [scpr_pkg::CountBits-1:0] fault_count_ff, fault_count_in;
   logic [SW-1:0]                  page_ff, page_in;
   logic [NW-1:0]                  n_ff, n_in;
   logic [NW-1:0]                  scan_ff, scan_in;
   logic                           cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]                  cmp_idx_ff, cmp_idx_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_fault_ff, rsp_fault_in;
   logic [scpr_pkg::PortIndex-1:0] rsp_index_ff, rsp_index_in;
   logic                           rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [scpr_pkg::PortPage-1:0]  rsp_ev_page_ff, rsp_ev_page_in;
   logic [scpr_pkg::CountBits-1:0] rsp_total_ff, rsp_total_in;

   logic          ram_wr_en, ram_rd_en;
   logic [IW-1:0] ram_wr_addr, ram_rd_addr;
   logic [SW-1:0] ram_rd_data;

   logic          hit, last, cur_valid, cur_ref, accept;
   logic [IW-1:0] hand_next;
   logic [scpr_pkg::CountBits-1:0] count_inc;

   scpr_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (page_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy      = (state_ff != scpr_pkg::ST_IDLE);
   assign csr_ready = ~busy;
   assign accept    = start & ~busy;

   assign hit       = cmp_valid_ff & valid_ff[cmp_idx_ff] & (ram_rd_data == page_ff);
   assign last      = cmp_valid_ff & (NW'(cmp_idx_ff) == n_ff - NW'(1));
   assign cur_valid = valid_ff[hand_ff];
   assign cur_ref   = ref_ff[hand_ff];
   assign hand_next = (NW'(hand_ff) + NW'(1) >= n_ff) ? '0 : hand_ff + IW'(1);
   assign count_inc = (fault_count_ff == '1) ? fault_count_ff
                                             : fault_count_ff + scpr_pkg::CountBits'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scpr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = scpr_pkg::ST_SEARCH;
            end
         end
         scpr_pkg::ST_SEARCH: begin
            if (hit) begin
               state_in = scpr_pkg::ST_IDLE;
            end else if (last) begin
               state_in = scpr_pkg::ST_SWEEP;
            end
         end
         scpr_pkg::ST_SWEEP: begin
            if (cur_valid && cur_ref) begin
               state_in = scpr_pkg::ST_SWEEP;
            end else if (cur_valid) begin
               state_in = scpr_pkg::ST_EVICT;
            end else begin
               state_in = scpr_pkg::ST_IDLE;
            end
         end
         scpr_pkg::ST_EVICT: begin
            state_in = scpr_pkg::ST_IDLE;
         end
         default: begin
            state_in = scpr_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      frame_count_in  = frame_count_ff;
      valid_in        = valid_ff;
      ref_in          = ref_ff;
      hand_in         = hand_ff;
      fault_count_in  = fault_count_ff;
      page_in         = page_ff;
      n_in            = n_ff;
      scan_in         = scan_ff;
      cmp_valid_in    = 1'b0;
      cmp_idx_in      = cmp_idx_ff;
      rsp_valid_in    = 1'b0;
      rsp_fault_in    = rsp_fault_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_total_in    = rsp_total_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = hand_ff;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = hand_ff;

      if (csr_valid && csr_ready) begin
         frame_count_in = csr_frame_count;
      end

      case (state_ff)
         scpr_pkg::ST_IDLE: begin
            if (accept) begin
               page_in = SW'(req_page_number);
               if (frame_count_ff == '0) begin
                  n_in = NW'(1);
               end else if (32'(frame_count_ff) > MAX_FRAMES) begin
                  n_in = NW'(MAX_FRAMES);
               end else begin
                  n_in = NW'(frame_count_ff);
               end
               scan_in = '0;
            end
         end
         scpr_pkg::ST_SEARCH: begin
            // pipelined scan: read frame scan_ff, compare the previous read
            if (scan_ff < n_ff) begin
               ram_rd_en    = 1'b1;
               ram_rd_addr  = IW'(scan_ff);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = IW'(scan_ff);
               scan_in      = scan_ff + NW'(1);
            end
            if (hit) begin
               cmp_valid_in            = 1'b0;
               ref_in[cmp_idx_ff]      = 1'b1;
               rsp_valid_in            = 1'b1;
               rsp_fault_in            = 1'b0;
               rsp_index_in            = scpr_pkg::PortIndex'(32'(cmp_idx_ff));
               rsp_ev_valid_in         = 1'b0;
               rsp_ev_page_in          = '0;
               rsp_total_in            = fault_count_ff;
            end else if (last) begin
               cmp_valid_in = 1'b0;
               // hand outside the frames in use wraps to frame 0
               if (NW'(hand_ff) >= n_ff) begin
                  hand_in = '0;
               end
            end
         end
         scpr_pkg::ST_SWEEP: begin
            if (cur_valid && cur_ref) begin
               ref_in[hand_ff] = 1'b0;
               hand_in         = hand_next;
            end else if (cur_valid) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = hand_ff;
            end else begin
               ram_wr_en        = 1'b1;
               valid_in[hand_ff] = 1'b1;
               ref_in[hand_ff]   = 1'b0;
               hand_in          = hand_next;
               fault_count_in   = count_inc;
               rsp_valid_in     = 1'b1;
               rsp_fault_in     = 1'b1;
               rsp_index_in     = scpr_pkg::PortIndex'(32'(hand_ff));
               rsp_ev_valid_in  = 1'b0;
               rsp_ev_page_in   = '0;
               rsp_total_in     = count_inc;
            end
         end
         scpr_pkg::ST_EVICT: begin
            ram_wr_en         = 1'b1;
            valid_in[hand_ff] = 1'b1;
            ref_in[hand_ff]   = 1'b0;
            hand_in           = hand_next;
            fault_count_in    = count_inc;
            rsp_valid_in      = 1'b1;
            rsp_fault_in      = 1'b1;
            rsp_index_in      = scpr_pkg::PortIndex'(32'(hand_ff));
            rsp_ev_valid_in   = 1'b1;
            rsp_ev_page_in    = scpr_pkg::PortPage'(32'(ram_rd_data));
            rsp_total_in      = count_inc;
         end
         default: begin
            cmp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= scpr_pkg::ST_IDLE;
         frame_count_ff <= scpr_pkg::CfgBits'(4);
         valid_ff       <= '0;
         ref_ff         <= '0;
         hand_ff        <= '0;
         fault_count_ff <= '0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         valid_ff       <= valid_in;
         ref_ff         <= ref_in;
         hand_ff        <= hand_in;
         fault_count_ff <= fault_count_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      n_ff            <= n_in;
      scan_ff         <= scan_in;
      cmp_idx_ff      <= cmp_idx_in;
      rsp_fault_ff    <= rsp_fault_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_total_ff    <= rsp_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_frame_index   = rsp_index_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_total_ff;

endmodule

>>> src/scpr_checker.sv
// port level checks for the second chance page replacement block
// depends on second_chance_page_replacement_defines.svh; bound to the top level
`include "second_chance_page_replacement_defines.svh"

module scpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_fault,
   input logic        rsp_evicted_valid,
   input logic [7:0]  rsp_evicted_page
);

   // a request transfer makes the block busy
   `SCPR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request transfer did not set busy")

   // the result strobe comes with the block free again
   `SCPR_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result shown while busy")

   // a hit never evicts
   `SCPR_ASSERT_NOW(a_hit_no_evict, rsp_valid && !rsp_fault,
      !rsp_evicted_valid && rsp_evicted_page == 8'd0, "hit reported an eviction")

   // an eviction only happens on a fault
   `SCPR_ASSERT_NOW(a_evict_fault, rsp_valid && rsp_evicted_valid, rsp_fault,
      "eviction without fault")

endmodule

bind second_chance_page_replacement scpr_checker u_scpr_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_fault         (rsp_fault),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page)
);
